[rtl/whp_pkg.sv]
// Shared types and constants for the WAV header parser.
// Used by wav_header_parser, whp_out_reg, whp_checker and tb_top; depends on nothing else.

package whp_pkg;

  // One byte of the incoming file stream.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       file_start;
  } whp_in_t;

  // One result: header summary, payload byte or error report.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [2:0]  error_code;
    logic [2:0]  sound_format;
    logic [15:0] audio_format_tag;
    logic [15:0] channel_total;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] payload_size;
  } whp_result_t;

  // Result kinds
  localparam logic [1:0] KIND_SUMMARY = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_RIFF     = 3'd1;
  localparam logic [2:0] ERR_WAVE     = 3'd2;
  localparam logic [2:0] ERR_FMT      = 3'd3;
  localparam logic [2:0] ERR_DATA     = 3'd4;
  localparam logic [2:0] ERR_DEPTH    = 3'd5;
  localparam logic [2:0] ERR_CHANNELS = 3'd6;

  // Chunk tags, first byte in the top position
  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_CUE  = 32'h63756520;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

endpackage

[rtl/whp_out_reg.sv]
// Result register between the parser and the output channel.
// Depends on whp_pkg for the result type.

module whp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_valid_i,
  input  whp_pkg::whp_result_t load_data_i,
  output logic                load_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output whp_pkg::whp_result_t out_data_o
);

  logic                 valid_q;
  whp_pkg::whp_result_t data_q;
  logic                 open;

  // The slot takes a new result when empty or when its content leaves this cycle.
  assign open         = !valid_q || !out_stall_i;
  assign load_stall_o = !open;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (open) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (open && load_valid_i) begin
      data_q <= load_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/wav_header_parser.sv]
// Top level of the WAV header parser: byte-wise parse state machine.
// Depends on whp_pkg and whp_out_reg.

// Accepts one file byte per cycle and yields at most one result for it in the next
// cycle, through a single result register. The parse update for a byte is one
// pass of logic from the state registers into that register, so bytes flow back
// to back; the input stalls only while a finished result is held and the output
// side stalls. A byte marked file_start restarts the parser on that byte.

module wav_header_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  whp_pkg::whp_in_t     in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output whp_pkg::whp_result_t out_data_o
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RIFF,
    PH_FSIZE,
    PH_WAVE,
    PH_FMT,
    PH_FMTBODY,
    PH_CHUNK,
    PH_CUESIZE,
    PH_SKIP,
    PH_DATA,
    PH_DSIZE,
    PH_PAYLOAD,
    PH_DONE
  } phase_e;

  localparam logic [4:0] OFS_WORD_LAST = 5'd3;
  localparam logic [4:0] OFS_FMT_LAST  = 5'd19;

  phase_e      phase_q, phase_d;
  logic [4:0]  offset_q, offset_d;
  logic [23:0] tag_q, tag_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] rem_q, rem_d;

  logic                 accept;
  logic [7:0]           b;
  logic [31:0]          tag_word;
  logic [1:0]           depth;
  logic                 depth_ok;
  logic                 res_valid;
  whp_pkg::whp_result_t res;

  assign accept = in_valid_i && !in_stall_o;
  assign b      = in_data_i.byte_value;

  always_comb begin
    depth_ok = 1'b1;
    case (bits_d)
      16'd8:   depth = 2'd0;
      16'd16:  depth = 2'd1;
      16'd32:  depth = 2'd2;
      16'd64:  depth = 2'd3;
      default: begin
        depth    = 2'd0;
        depth_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    offset_d  = offset_q;
    tag_d     = tag_q;
    fmt_d     = fmt_q;
    chan_d    = chan_q;
    rate_d    = rate_q;
    bits_d    = bits_q;
    rem_d     = rem_q;
    tag_word  = {tag_q, b};
    res_valid = 1'b0;
    res       = '0;

    if (accept) begin
      if (in_data_i.file_start) begin
        phase_d  = PH_RIFF;
        offset_d = '0;
        tag_d    = '0;
        fmt_d    = '0;
        chan_d   = '0;
        rate_d   = '0;
        bits_d   = '0;
        rem_d    = '0;
      end
      tag_word = {tag_d, b};

      case (phase_d)
        PH_RIFF, PH_WAVE, PH_FMT, PH_CHUNK, PH_DATA: begin
          tag_d = tag_word[23:0];
          if (offset_d != OFS_WORD_LAST) begin
            offset_d = offset_d + 5'd1;
          end else begin
            offset_d = '0;
            if (phase_d == PH_RIFF && tag_word != whp_pkg::TAG_RIFF) begin
              res_valid = 1'b1;
              res.error_code = whp_pkg::ERR_RIFF;
            end else if (phase_d == PH_RIFF) begin
              phase_d = PH_FSIZE;
            end else if (phase_d == PH_WAVE && tag_word != whp_pkg::TAG_WAVE) begin
              res_valid = 1'b1;
              res.error_code = whp_pkg::ERR_WAVE;
            end else if (phase_d == PH_WAVE) begin
              phase_d = PH_FMT;
            end else if (phase_d == PH_FMT && tag_word != whp_pkg::TAG_FMT) begin
              res_valid = 1'b1;
              res.error_code = whp_pkg::ERR_FMT;
            end else if (phase_d == PH_FMT) begin
              phase_d = PH_FMTBODY;
            end else if (phase_d == PH_CHUNK && tag_word == whp_pkg::TAG_CUE) begin
              phase_d = PH_CUESIZE;
            end else if (tag_word != whp_pkg::TAG_DATA) begin
              res_valid = 1'b1;
              res.error_code = whp_pkg::ERR_DATA;
            end else begin
              phase_d = PH_DSIZE;
            end
          end
        end
        PH_FSIZE: begin
          if (offset_d != OFS_WORD_LAST) begin
            offset_d = offset_d + 5'd1;
          end else begin
            offset_d = '0;
            phase_d  = PH_WAVE;
          end
        end
        PH_FMTBODY: begin
          // Fields start cleared, so each byte lane is simply written.
          case (offset_d)
            5'd4:    fmt_d[7:0]    = b;
            5'd5:    fmt_d[15:8]   = b;
            5'd6:    chan_d[7:0]   = b;
            5'd7:    chan_d[15:8]  = b;
            5'd8:    rate_d[7:0]   = b;
            5'd9:    rate_d[15:8]  = b;
            5'd10:   rate_d[23:16] = b;
            5'd11:   rate_d[31:24] = b;
            5'd18:   bits_d[7:0]   = b;
            5'd19:   bits_d[15:8]  = b;
            default: ;
          endcase
          if (offset_d != OFS_FMT_LAST) begin
            offset_d = offset_d + 5'd1;
          end else begin
            offset_d = '0;
            phase_d  = PH_CHUNK;
          end
        end
        PH_CUESIZE, PH_DSIZE: begin
          rem_d = {b, rem_d[31:8]};
          if (offset_d != OFS_WORD_LAST) begin
            offset_d = offset_d + 5'd1;
          end else begin
            offset_d = '0;
            if (phase_d == PH_CUESIZE) begin
              phase_d = (rem_d == 32'd0) ? PH_DATA : PH_SKIP;
            end else if (!depth_ok) begin
              res_valid = 1'b1;
              res.error_code = whp_pkg::ERR_DEPTH;
            end else if (chan_d != 16'd1 && chan_d != 16'd2) begin
              res_valid = 1'b1;
              res.error_code = whp_pkg::ERR_CHANNELS;
            end else begin
              res_valid = 1'b1;
              res.result_kind      = whp_pkg::KIND_SUMMARY;
              res.last_payload     = (rem_d == 32'd0);
              res.sound_format     = {depth, chan_d == 16'd2};
              res.audio_format_tag = fmt_d;
              res.channel_total    = chan_d;
              res.sample_rate      = rate_d;
              res.sample_bits      = bits_d;
              res.payload_size     = rem_d;
              phase_d = (rem_d == 32'd0) ? PH_DONE : PH_PAYLOAD;
            end
          end
        end
        PH_SKIP: begin
          rem_d = rem_d - 32'd1;
          if (rem_d == 32'd0) begin
            phase_d = PH_DATA;
          end
        end
        PH_PAYLOAD: begin
          rem_d = rem_d - 32'd1;
          res_valid = 1'b1;
          res.result_kind  = whp_pkg::KIND_PAYLOAD;
          res.payload_byte = b;
          res.last_payload = (rem_d == 32'd0);
          if (rem_d == 32'd0) begin
            phase_d = PH_DONE;
          end
        end
        default: ;
      endcase

      // Any error ends the file.
      if (res_valid && res.error_code != 3'd0) begin
        res.result_kind = whp_pkg::KIND_ERROR;
        phase_d = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      offset_q <= '0;
      tag_q    <= '0;
      fmt_q    <= '0;
      chan_q   <= '0;
      rate_q   <= '0;
      bits_q   <= '0;
      rem_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      offset_q <= offset_d;
      tag_q    <= tag_d;
      fmt_q    <= fmt_d;
      chan_q   <= chan_d;
      rate_q   <= rate_d;
      bits_q   <= bits_d;
      rem_q    <= rem_d;
    end
  end

  whp_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (res_valid),
    .load_data_i  (res),
    .load_stall_o (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

[verif/whp_checker.sv]
// Checker for wav_header_parser: watches both request channels, predicts results.
// Depends on whp_pkg; hands its mismatch and outstanding counts to tb_top.

module whp_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  whp_pkg::whp_in_t     in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  whp_pkg::whp_result_t out_data_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          awaited_count_o
);
  import whp_pkg::*;

  typedef enum logic [3:0] {
    SEEK_START, RIFF_TAG, FILE_SIZE, WAVE_TAG, FMT_TAG, FMT_BODY, CHUNK_TAG,
    CUE_SIZE, CUE_SKIP, DATA_TAG, DATA_SIZE, PAYLOAD, FILE_DONE
  } parse_phase_e;

  parse_phase_e phase;
  int unsigned  offset;
  logic [31:0]  tag_sr;
  logic [15:0]  fmt_code;
  logic [15:0]  chans;
  logic [31:0]  rate;
  logic [15:0]  depth_bits;
  logic [31:0]  remaining;

  whp_result_t  awaited_results[$];
  int unsigned  errors = 0;

  function automatic void clear_parser();
    phase      = SEEK_START;
    offset     = 0;
    tag_sr     = '0;
    fmt_code   = '0;
    chans      = '0;
    rate       = '0;
    depth_bits = '0;
    remaining  = '0;
  endfunction

  function automatic bit reject(output whp_result_t res, input logic [2:0] code);
    res             = '0;
    res.result_kind = KIND_ERROR;
    res.error_code  = code;
    phase           = FILE_DONE;
    return 1'b1;
  endfunction

  // Advance the parse by one byte; return 1 when the byte yields a result.
  function automatic bit parse_byte(input whp_in_t req, output whp_result_t res);
    logic [7:0] b;
    logic [1:0] depth;
    b   = req.byte_value;
    res = '0;
    if (req.file_start) begin
      clear_parser();
      phase = RIFF_TAG;
    end
    case (phase)
      RIFF_TAG, WAVE_TAG, FMT_TAG, CHUNK_TAG, DATA_TAG: begin
        tag_sr = {tag_sr[23:0], b};
        offset = offset + 1;
        if (offset < 4) return 1'b0;
        offset = 0;
        case (phase)
          RIFF_TAG: begin
            if (tag_sr != TAG_RIFF) return reject(res, ERR_RIFF);
            phase = FILE_SIZE;
          end
          WAVE_TAG: begin
            if (tag_sr != TAG_WAVE) return reject(res, ERR_WAVE);
            phase = FMT_TAG;
          end
          FMT_TAG: begin
            if (tag_sr != TAG_FMT) return reject(res, ERR_FMT);
            phase = FMT_BODY;
          end
          CHUNK_TAG: begin
            if (tag_sr == TAG_CUE) phase = CUE_SIZE;
            else if (tag_sr == TAG_DATA) phase = DATA_SIZE;
            else return reject(res, ERR_DATA);
          end
          default: begin
            // only one cue chunk: data must follow it
            if (tag_sr != TAG_DATA) return reject(res, ERR_DATA);
            phase = DATA_SIZE;
          end
        endcase
        return 1'b0;
      end
      FILE_SIZE: begin
        offset = offset + 1;
        if (offset >= 4) begin
          offset = 0;
          phase  = WAVE_TAG;
        end
        return 1'b0;
      end
      FMT_BODY: begin
        if (offset == 4 || offset == 5)
          fmt_code = fmt_code | (16'(b) << (8 * (offset - 4)));
        else if (offset == 6 || offset == 7)
          chans = chans | (16'(b) << (8 * (offset - 6)));
        else if (offset >= 8 && offset <= 11)
          rate = rate | (32'(b) << (8 * (offset - 8)));
        else if (offset == 18 || offset == 19)
          depth_bits = depth_bits | (16'(b) << (8 * (offset - 18)));
        offset = offset + 1;
        if (offset >= 20) begin
          offset = 0;
          phase  = CHUNK_TAG;
        end
        return 1'b0;
      end
      CUE_SIZE, DATA_SIZE: begin
        remaining = {b, remaining[31:8]};
        offset    = offset + 1;
        if (offset < 4) return 1'b0;
        offset = 0;
        if (phase == CUE_SIZE) begin
          phase = (remaining == 0) ? DATA_TAG : CUE_SKIP;
          return 1'b0;
        end
        case (depth_bits)
          16'd8:   depth = 2'd0;
          16'd16:  depth = 2'd1;
          16'd32:  depth = 2'd2;
          16'd64:  depth = 2'd3;
          default: return reject(res, ERR_DEPTH);
        endcase
        if (chans != 16'd1 && chans != 16'd2) return reject(res, ERR_CHANNELS);
        res.result_kind      = KIND_SUMMARY;
        res.last_payload     = (remaining == 0);
        res.sound_format     = {depth, chans == 16'd2};
        res.audio_format_tag = fmt_code;
        res.channel_total    = chans;
        res.sample_rate      = rate;
        res.sample_bits      = depth_bits;
        res.payload_size     = remaining;
        phase = (remaining == 0) ? FILE_DONE : PAYLOAD;
        return 1'b1;
      end
      CUE_SKIP: begin
        remaining = remaining - 1;
        if (remaining == 0) phase = DATA_TAG;
        return 1'b0;
      end
      PAYLOAD: begin
        remaining        = remaining - 1;
        res.result_kind  = KIND_PAYLOAD;
        res.payload_byte = b;
        res.last_payload = (remaining == 0);
        if (remaining == 0) phase = FILE_DONE;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors = errors + 1;
      if (errors <= 10)
        $display("[%0t] %s mismatch: expected %h, got %h", $realtime, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk_i) begin : watch
    whp_result_t want;
    whp_result_t seen;
    if (!rst_ni) begin
      clear_parser();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (parse_byte(in_data_i, want)) awaited_results.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        seen = out_data_i;
        if (awaited_results.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("[%0t] result with none awaited: kind %0d", $realtime, seen.result_kind);
        end else begin
          want = awaited_results.pop_front();
          compare_field("result_kind", 32'(want.result_kind), 32'(seen.result_kind));
          compare_field("payload_byte", 32'(want.payload_byte), 32'(seen.payload_byte));
          compare_field("last_payload", 32'(want.last_payload), 32'(seen.last_payload));
          compare_field("error_code", 32'(want.error_code), 32'(seen.error_code));
          compare_field("sound_format", 32'(want.sound_format), 32'(seen.sound_format));
          compare_field("audio_format_tag", 32'(want.audio_format_tag),
                        32'(seen.audio_format_tag));
          compare_field("channel_total", 32'(want.channel_total), 32'(seen.channel_total));
          compare_field("sample_rate", want.sample_rate, seen.sample_rate);
          compare_field("sample_bits", 32'(want.sample_bits), 32'(seen.sample_bits));
          compare_field("payload_size", want.payload_size, seen.payload_size);
        end
      end
    end
    mismatch_count_o <= errors;
    awaited_count_o  <= awaited_results.size();
  end

endmodule

[verif/tb_top.sv]
// Testbench top for wav_header_parser: builds WAV byte streams and drives them.
// Depends on whp_pkg, wav_header_parser and whp_checker, which does the checking.

module tb_top;
  import whp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned CONTENT_GOAL = 1950;

  typedef struct {
    logic [31:0] riff_tag;
    logic [31:0] wave_tag;
    logic [31:0] fmt_tag;
    logic [31:0] fmt_len;
    logic [15:0] format_tag;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] depth_bits;
    bit          has_cue;
    logic [31:0] cue_len;
    int          cue_fill;
    logic [31:0] data_tag;
    logic [31:0] data_len;
    int          body_len;
    int          cut;
  } wav_desc_t;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        in_valid_i = 1'b0;
  whp_in_t     in_data_i  = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  whp_result_t out_data_o;

  int unsigned mismatch_count;
  int unsigned awaited_count;
  int unsigned cycle_count = 0;
  int unsigned content_bytes = 0;
  bit          calm = 1'b0;
  logic [7:0]  wav_img[$];

  wav_header_parser i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  whp_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_data_i      (out_data_o),
    .mismatch_count_o(mismatch_count),
    .awaited_count_o (awaited_count)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stall before each request, plus a long hold now and then.
  initial begin : result_sink
    int          hold;
    int unsigned taken;
    int unsigned next_long;
    taken     = 0;
    next_long = 150;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 12);
      if (taken >= next_long && out_data_o.result_kind == KIND_PAYLOAD &&
          !out_data_o.last_payload) begin
        hold      = 120;
        next_long = taken + 300;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken = taken + 1;
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic start);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{byte_value: value, file_start: start};
    do @(posedge clk_i); while (in_stall_o);
    content_bytes = content_bytes + 1;
  endtask

  // Hold the sender until every awaited result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
  endtask

  function automatic void put_be32(logic [31:0] v);
    for (int k = 3; k >= 0; k--) wav_img.push_back(v[8*k +: 8]);
  endfunction

  function automatic void put_le32(logic [31:0] v);
    for (int k = 0; k < 4; k++) wav_img.push_back(v[8*k +: 8]);
  endfunction

  function automatic void put_le16(logic [15:0] v);
    wav_img.push_back(v[7:0]);
    wav_img.push_back(v[15:8]);
  endfunction

  function automatic wav_desc_t good_wav();
    wav_desc_t d;
    d.riff_tag   = TAG_RIFF;
    d.wave_tag   = TAG_WAVE;
    d.fmt_tag    = TAG_FMT;
    d.fmt_len    = $urandom();
    d.format_tag = 16'd1;
    d.channels   = 16'($urandom_range(1, 2));
    d.rate       = $urandom();
    d.depth_bits = 16'(8 << $urandom_range(0, 3));
    d.has_cue    = 1'b0;
    d.cue_len    = '0;
    d.cue_fill   = 0;
    d.data_tag   = TAG_DATA;
    d.data_len   = $urandom_range(0, 40);
    d.body_len   = int'(d.data_len);
    d.cut        = 0;
    return d;
  endfunction

  task automatic send_file(input wav_desc_t d);
    int n;
    int i;
    wav_img.delete();
    put_be32(d.riff_tag);
    put_le32($urandom());
    put_be32(d.wave_tag);
    put_be32(d.fmt_tag);
    put_le32(d.fmt_len);
    put_le16(d.format_tag);
    put_le16(d.channels);
    put_le32(d.rate);
    put_le32($urandom());
    put_le16(16'($urandom()));
    put_le16(d.depth_bits);
    if (d.has_cue) begin
      put_be32(TAG_CUE);
      put_le32(d.cue_len);
      repeat (d.cue_fill) wav_img.push_back(8'($urandom()));
    end
    put_be32(d.data_tag);
    put_le32(d.data_len);
    repeat (d.body_len) wav_img.push_back(8'($urandom()));
    n = (d.cut > 0 && d.cut < wav_img.size()) ? d.cut : wav_img.size();
    for (i = 0; i < n; i++) send_byte(wav_img[i], i == 0);
  endtask

  task automatic run_directed();
    wav_desc_t d;
    // bytes before any file start are dropped
    send_byte(8'h52, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    for (int k = 0; k < 19; k++) begin
      d = good_wav();
      case (k)
        0: begin
          d.channels = 16'd1; d.depth_bits = 16'd8; d.rate = '0;
          d.data_len = 32'd3; d.body_len = 3;
        end
        1: begin
          d.channels = 16'd2; d.depth_bits = 16'd64; d.rate = '1; d.format_tag = '1;
          d.data_len = '0; d.body_len = 2;
        end
        2: begin
          d.channels = 16'd2; d.depth_bits = 16'd16; d.has_cue = 1'b1;
          d.data_len = 32'd2; d.body_len = 2;
        end
        3: begin
          d.channels = 16'd1; d.depth_bits = 16'd32; d.has_cue = 1'b1;
          d.cue_len = 32'd3; d.cue_fill = 3; d.data_len = 32'd1; d.body_len = 1;
        end
        4:  d.riff_tag = TAG_RIFF ^ 32'h0000_0001;
        5:  d.wave_tag = TAG_WAVE ^ 32'hFF00_0000;
        6:  d.fmt_tag  = TAG_FMT ^ 32'h0000_0100;
        7:  d.data_tag = 32'h4C49_5354;
        8: begin
          d.has_cue = 1'b1; d.data_tag = TAG_CUE;
        end
        9: begin
          d.has_cue = 1'b1; d.cue_len = 32'd2; d.cue_fill = 2;
          d.data_tag = TAG_DATA ^ 32'h0001_0000;
        end
        10: begin
          d.depth_bits = 16'd24; d.channels = 16'd3;
        end
        11: d.depth_bits = '0;
        12: d.depth_bits = '1;
        13: d.channels = '0;
        14: d.channels = '1;
        15: begin
          d.format_tag = '0; d.data_len = 32'd1; d.body_len = 1;
        end
        16: begin
          d.data_len = '1; d.body_len = 4;
        end
        17: begin
          d.has_cue = 1'b1; d.cue_len = '1; d.cue_fill = 5;
        end
        default: d.cut = 10;
      endcase
      send_file(d);
    end
    send_file(good_wav());
  endtask

  initial begin : stimulus
    wav_desc_t d;
    int        pick;
    int        which;
    logic [31:0] flip;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    drain();

    while (content_bytes < CONTENT_GOAL) begin
      d    = good_wav();
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        d.has_cue  = 1'b1;
        d.cue_len  = $urandom_range(0, 6);
        d.cue_fill = int'(d.cue_len);
      end else if (pick < 25) begin
        // break exactly one byte of one tag
        which = $urandom_range(0, 3);
        flip  = 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
        case (which)
          0:       d.riff_tag = d.riff_tag ^ flip;
          1:       d.wave_tag = d.wave_tag ^ flip;
          2:       d.fmt_tag  = d.fmt_tag ^ flip;
          default: d.data_tag = d.data_tag ^ flip;
        endcase
      end else if (pick < 30) begin
        d.depth_bits = 16'($urandom());
      end else if (pick < 35) begin
        d.channels = 16'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) d.channels = 16'($urandom());
      end else if (pick < 40) begin
        d.format_tag = 16'($urandom());
      end else if (pick < 45) begin
        d.cut = $urandom_range(1, 60);
      end else if (pick < 50) begin
        if (d.body_len > 0) d.body_len = $urandom_range(0, d.body_len - 1);
      end else if (pick < 55) begin
        d.body_len = d.body_len + $urandom_range(1, 6);
      end else if (pick < 60) begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom()), 1'b0);
      end
      send_file(d);
      if ($urandom_range(0, 7) == 0) drain();
    end

    calm = 1'b0;
    drain();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/whp_pkg.sv
rtl/whp_out_reg.sv
rtl/wav_header_parser.sv
verif/whp_checker.sv
verif/tb_top.sv
